// ===== rtl/drdc_pkg.sv =====
// drdc_pkg: shared widths, field offsets and constants for the DMA record
// deframe checker and its port checker.
// No dependencies.
package drdc_pkg;

    // Length field width taken from the first header word (8 to 32)
    localparam int LEN_W = 32;
    // Word position inside a record never exceeds length/4 - 1
    localparam int POS_W = LEN_W - 2;

    localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(16);

    // End-of-frame patterns
    localparam logic [31:0] EOF_PAT_A = 32'hBC95_7575;
    localparam logic [31:0] EOF_PAT_B = 32'hBCB5_7575;
    localparam logic [31:0] EOF_PAT_C = 32'hBC95_D5D5;
    localparam logic [31:0] EOF_PAT_D = 32'hBCB5_D5D5;

    // Register reset values
    localparam logic [31:0] CFG_ID_RESET = 32'hFC00_0000;
    localparam logic [31:0] MON_ID_RESET = 32'hFB00_0000;

    // APB register map, decoded on address bit 2
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_CFG_ID = 1'b0;
    localparam logic [0:0] REG_MON_ID = 1'b1;

    // Result tdata layout, lowest bit first
    localparam int OFS_REC_END   = 0;
    localparam int OFS_HDR_BAD   = 1;
    localparam int OFS_EOF_BAD   = 2;
    localparam int OFS_LEN_BAD   = 3;
    localparam int OFS_TRUNC     = 4;
    localparam int OFS_FRAMES    = 5;
    localparam int OFS_PAYLOAD   = 69;
    localparam int OFS_BUFFERS   = 133;
    localparam int OFS_BUF_BYTES = 197;
    localparam int OFS_HDR_ERRS  = 261;
    localparam int RES_W         = 293;
    localparam int RES_TDATA_W   = 296;

endpackage

// ===== rtl/dma_record_deframe_check_unit.sv =====
// dma_record_deframe_check_unit: record deframing, header/length/EOF checks
// and running statistics over a stream of DMA buffer words.
// Depends on drdc_pkg.

// The block takes one 32-bit buffer word per cycle and returns one result
// per word, in the cycle after the word is accepted. Words may follow one
// another in every cycle; s_axis_tready stays high while the result stage
// is empty or its result is being taken in the same cycle, so the rate is
// set only by the single output register. The result carries five flags
// for this word and the statistics counters as they stand after it.
// tlast marks the last word of a buffer, tuser clears all counters before
// the word is counted. Register writes are taken at any time but are meant
// for idle periods.
module dma_record_deframe_check_unit
    import drdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Word stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // data_word
    input  logic                   s_axis_tlast,   // buffer_last
    input  logic                   s_axis_tuser,   // clear_stats
    // Result stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // record_end, header_bad, eof_bad, length_bad, truncated, frame_total[64],
    // payload_byte_total[64], buffer_total[64], buffer_byte_total[64],
    // header_error_total[32], zero pad[3]
    output logic [RES_TDATA_W-1:0] m_axis_tdata
);

    // Configuration registers
    logic [31:0] r_cfg_id;
    logic [31:0] r_mon_id;

    // Parser state
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_last_pos;
    logic [LEN_W-1:0] r_payload_len;
    logic             r_cfg_match;

    // Counters (also the result payload)
    logic [63:0] r_frames;
    logic [63:0] r_payload;
    logic [63:0] r_buffers;
    logic [63:0] r_buf_bytes;
    logic [31:0] r_hdr_errs;

    // Result flags and output valid
    logic       r_out_valid;
    logic [4:0] r_flags;

    logic             accept;
    logic [LEN_W-1:0] len;
    logic             at_header;
    logic             len_ok;
    logic             rec_end;
    logic             hdr_bad;
    logic             eof_bad;
    logic             len_bad;
    logic             trunc;
    logic             eof_hit;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] pos_after;
    logic             n_cfg_match;
    logic [63:0]      base_frames;
    logic [63:0]      base_payload;
    logic [63:0]      base_buffers;
    logic [63:0]      base_buf_bytes;
    logic [31:0]      base_hdr_errs;

    // APB: always ready, write on access phase
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_CFG_ID: prdata = r_cfg_id;
            REG_MON_ID: prdata = r_mon_id;
            default:    prdata = r_cfg_id;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_id <= CFG_ID_RESET;
            r_mon_id <= MON_ID_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_CFG_ID: r_cfg_id <= pwdata;
                REG_MON_ID: r_mon_id <= pwdata;
                default: ;
            endcase
        end
    end

    // Handshake: take a word when the result stage is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Per-word parsing
    always_comb begin
        len       = s_axis_tdata[LEN_W-1:0];
        at_header = (r_pos == '0);
        len_ok    = (len >= HEADER_BYTES) && (len[1:0] == 2'b00);
        eof_hit   = (s_axis_tdata == EOF_PAT_A) || (s_axis_tdata == EOF_PAT_B) ||
                    (s_axis_tdata == EOF_PAT_C) || (s_axis_tdata == EOF_PAT_D);

        len_bad     = at_header && !len_ok;
        rec_end     = !at_header && (r_pos == r_last_pos);
        eof_bad     = rec_end && !eof_hit;
        hdr_bad     = !at_header && (r_pos == POS_W'(3)) && !r_cfg_match &&
                      (s_axis_tdata != r_mon_id);

        n_cfg_match = r_cfg_match;
        if (!at_header && (r_pos == POS_W'(2))) begin
            n_cfg_match = (s_axis_tdata == r_cfg_id);
        end

        // next position before the buffer-end check
        if (at_header) begin
            pos_after = len_ok ? POS_W'(1) : '0;
        end else if (rec_end) begin
            pos_after   = '0;
            n_cfg_match = 1'b0;
        end else begin
            pos_after = r_pos + POS_W'(1);
        end

        // buffer end cuts off an unfinished record
        trunc = s_axis_tlast && (pos_after != '0);
        n_pos = trunc ? '0 : pos_after;
        if (trunc) begin
            n_cfg_match = 1'b0;
        end
    end

    // Counter bases after an optional clear
    always_comb begin
        base_frames    = s_axis_tuser ? '0 : r_frames;
        base_payload   = s_axis_tuser ? '0 : r_payload;
        base_buffers   = s_axis_tuser ? '0 : r_buffers;
        base_buf_bytes = s_axis_tuser ? '0 : r_buf_bytes;
        base_hdr_errs  = s_axis_tuser ? '0 : r_hdr_errs;
    end

    // Parser state and record length bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cfg_match <= 1'b0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_cfg_match <= n_cfg_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && at_header && len_ok) begin
            r_last_pos    <= POS_W'(len >> 2) - POS_W'(1);
            r_payload_len <= len - HEADER_BYTES;
        end
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= '0;
            r_payload   <= '0;
            r_buffers   <= '0;
            r_buf_bytes <= '0;
            r_hdr_errs  <= '0;
        end else if (accept) begin
            r_frames    <= base_frames + 64'(rec_end);
            r_payload   <= base_payload + (rec_end ? 64'(r_payload_len) : 64'd0);
            r_buffers   <= base_buffers + 64'(s_axis_tlast);
            r_buf_bytes <= base_buf_bytes + 64'd4;
            r_hdr_errs  <= base_hdr_errs + 32'(hdr_bad);
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags <= {trunc, len_bad, eof_bad, hdr_bad, rec_end};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_hdr_errs, r_buf_bytes, r_buffers,
                            r_payload, r_frames, r_flags};

endmodule

// ===== rtl/drdc_checker.sv =====
// drdc_checker: port-level checks on dma_record_deframe_check_unit, with
// the bind that attaches it.
// Depends on drdc_pkg.
module drdc_checker
    import drdc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [RES_TDATA_W-1:0] m_axis_tdata
);

    logic in_txn;
    assign in_txn = s_axis_tvalid && s_axis_tready;

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every accepted word yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn |=> m_axis_tvalid)
        else $error("no result after accepted word");

    // buffer bytes grow by four per word without a clear
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn && !s_axis_tuser |=>
            m_axis_tdata[OFS_BUF_BYTES +: 64] ==
            $past(m_axis_tdata[OFS_BUF_BYTES +: 64]) + 64'd4)
        else $error("buffer byte count out of step");

    // record end, bad length and truncation never come together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0({m_axis_tdata[OFS_REC_END],
                                    m_axis_tdata[OFS_LEN_BAD],
                                    m_axis_tdata[OFS_TRUNC]}))
        else $error("conflicting result flags");

endmodule

bind dma_record_deframe_check_unit drdc_checker u_drdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/drdc_score_pkg.sv =====
`timescale 1ns / 1ps
// drdc_score_pkg: scoreboard class for the DMA record deframe checker bench.
// It predicts the flags and counters per buffer word and checks the results.
// Depends on drdc_pkg.
package drdc_score_pkg;
    import drdc_pkg::*;

    // Expected outcome of one buffer word
    typedef struct {
        bit        rec_end;
        bit        hdr_bad;
        bit        eof_bad;
        bit        len_bad;
        bit        trunc;
        bit [63:0] frames;
        bit [63:0] payload;
        bit [63:0] buffers;
        bit [63:0] buf_bytes;
        bit [31:0] hdr_errs;
    } t_word_verdict;

    class record_stats_scoreboard;
        // register copies
        bit [31:0]      cfg_id = CFG_ID_RESET;
        bit [31:0]      mon_id = MON_ID_RESET;
        // deframer state
        bit [31:0]      next_pos;
        bit [LEN_W-1:0] rec_len;
        bit             cfg_hit;
        // statistics
        bit [63:0]      frames;
        bit [63:0]      payload;
        bit [63:0]      buffers;
        bit [63:0]      buf_bytes;
        bit [31:0]      hdr_errs;
        // verdicts still owed by the block
        t_word_verdict  verdicts_due[$];
        int unsigned    errors;
        int unsigned    results_seen;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        // Predict the outcome of one accepted buffer word
        function void note_word(bit [31:0] w, bit last, bit clr);
            t_word_verdict  v;
            bit [LEN_W-1:0] len;
            v = '{default: '0};
            if (clr) begin
                frames    = '0;
                payload   = '0;
                buffers   = '0;
                buf_bytes = '0;
                hdr_errs  = '0;
            end
            buf_bytes += 64'd4;

            if (next_pos == 0) begin
                // length word: bad length resyncs on the next word
                len = w[LEN_W-1:0];
                if (len < HEADER_BYTES || len[1:0] != 2'b00) begin
                    v.len_bad = 1'b1;
                end else begin
                    rec_len  = len;
                    next_pos = 1;
                end
            end else begin
                if (next_pos == 2)
                    cfg_hit = (w == cfg_id);
                if (next_pos == 3 && !cfg_hit && w != mon_id) begin
                    v.hdr_bad = 1'b1;
                    hdr_errs += 32'd1;
                end
                // last word of record, may be the monitor word itself
                if (next_pos == 32'(rec_len >> 2) - 32'd1) begin
                    v.rec_end = 1'b1;
                    v.eof_bad = !(w inside {EOF_PAT_A, EOF_PAT_B, EOF_PAT_C, EOF_PAT_D});
                    frames  += 64'd1;
                    payload += 64'(rec_len - HEADER_BYTES);
                    next_pos = 0;
                    cfg_hit  = 1'b0;
                end else begin
                    next_pos += 1;
                end
            end

            // buffer end cuts off any open record
            if (last) begin
                buffers += 64'd1;
                if (next_pos != 0) begin
                    v.trunc  = 1'b1;
                    next_pos = 0;
                    cfg_hit  = 1'b0;
                end
            end

            v.frames    = frames;
            v.payload   = payload;
            v.buffers   = buffers;
            v.buf_bytes = buf_bytes;
            v.hdr_errs  = hdr_errs;
            verdicts_due.push_back(v);
        endfunction

        task compare(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        // Check one result transaction against the oldest verdict
        task check_result(logic [RES_TDATA_W-1:0] d);
            t_word_verdict v;
            results_seen++;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result %0d arrived with no word outstanding",
                                 results_seen));
                return;
            end
            v = verdicts_due.pop_front();
            compare("record_end", d[OFS_REC_END], v.rec_end);
            compare("header_bad", d[OFS_HDR_BAD], v.hdr_bad);
            compare("eof_bad", d[OFS_EOF_BAD], v.eof_bad);
            compare("length_bad", d[OFS_LEN_BAD], v.len_bad);
            compare("truncated", d[OFS_TRUNC], v.trunc);
            compare("frame_total", d[OFS_FRAMES +: 64], v.frames);
            compare("payload_byte_total", d[OFS_PAYLOAD +: 64], v.payload);
            compare("buffer_total", d[OFS_BUFFERS +: 64], v.buffers);
            compare("buffer_byte_total", d[OFS_BUF_BYTES +: 64], v.buf_bytes);
            compare("header_error_total", d[OFS_HDR_ERRS +: 32], v.hdr_errs);
        endtask
    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: bench for dma_record_deframe_check_unit with directed and random
// buffer streams, random stalls on both sides and APB register phases.
// Depends on drdc_pkg, drdc_score_pkg and the unit RTL.
module tb_top;
    import drdc_pkg::*;
    import drdc_score_pkg::*;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata = '0;   // data_word
    logic                   s_axis_tlast = 1'b0; // buffer_last
    logic                   s_axis_tuser = 1'b0; // clear_stats
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // record_end, header_bad, eof_bad, length_bad, truncated, frame_total[64],
    // payload_byte_total[64], buffer_total[64], buffer_byte_total[64],
    // header_error_total[32], zero pad[3]
    logic [RES_TDATA_W-1:0] m_axis_tdata;

    record_stats_scoreboard sb;
    logic [31:0]            words_q[$];
    int unsigned            burst_left = 0;
    bit                     gaps_on = 1'b1;
    t_rx_mode               rx_mode = RX_OPEN;
    int unsigned            rx_span = 0;
    int unsigned            rx_tick = 0;

    dma_record_deframe_check_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Receiver stalls: modes held for random spans
    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_span = $urandom_range(20, 200);
        end
        rx_span--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:  m_axis_tready <= (rx_tick % 5 == 0);
        endcase
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Sender gap whose length is set by n
    task automatic hold_off(int unsigned n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_word(logic [31:0] w, bit last, bit clr);
        if (burst_left == 0) begin
            if (gaps_on)
                hold_off($urandom_range(0, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        s_axis_tuser  <= clr;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(w, last, clr);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic check_register(logic [0:0] idx, logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            sb.report($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(logic [0:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_CFG_ID)
            sb.cfg_id = value;
        else
            sb.mon_id = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_register(idx, value);
    endtask

    function automatic logic [31:0] pick_eof();
        case ($urandom_range(0, 3))
            0:       return EOF_PAT_A;
            1:       return EOF_PAT_B;
            2:       return EOF_PAT_C;
            default: return EOF_PAT_D;
        endcase
    endfunction

    // Mostly short records, a few longer ones
    function automatic logic [31:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd16;
        else if (r < 75)
            return 4 * $urandom_range(5, 12);
        else
            return 4 * $urandom_range(13, 40);
    endfunction

    // Length word that is too short or not word aligned
    function automatic logic [31:0] bad_len();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 15);
        else
            return ($urandom() & ~32'h3) | $urandom_range(1, 3);
    endfunction

    function automatic void add_record(logic [31:0] len, bit cfg_ok, bit mon_ok, bit eof_ok);
        int unsigned n;
        n = len >> 2;
        words_q.push_back(len);
        words_q.push_back($urandom());
        words_q.push_back(cfg_ok ? sb.cfg_id : $urandom());
        words_q.push_back(mon_ok ? sb.mon_id : $urandom());
        for (int k = 4; k < n; k++)
            words_q.push_back($urandom());
        if (eof_ok)
            words_q[words_q.size() - 1] = pick_eof();
    endfunction

    task automatic send_buffer();
        foreach (words_q[k])
            send_word(words_q[k], k == words_q.size() - 1, $urandom_range(0, 63) == 0);
    endtask

    // Random buffers: mostly well-formed record chains, some cut, some noise
    task automatic run_random(int unsigned quota);
        int unsigned sent;
        int unsigned kind;
        int unsigned keep;
        sent = 0;
        while (sent < quota) begin
            words_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) == 0)
                        words_q.push_back(bad_len());
                    add_record(pick_len(), $urandom_range(0, 3) != 0,
                               $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0);
                end
                // cut the buffer short
                if (kind >= 65) begin
                    keep = $urandom_range(1, words_q.size());
                    while (words_q.size() > keep) void'(words_q.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 12))
                    words_q.push_back(kind < 90 ? $urandom() : $urandom_range(0, 64));
            end
            send_buffer();
            sent += words_q.size();
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_register(REG_CFG_ID, CFG_ID_RESET);
        check_register(REG_MON_ID, MON_ID_RESET);

        // sixteen-byte record, both IDs good, monitor word is no EOF pattern
        send_word(32'd16, 1'b0, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(CFG_ID_RESET, 1'b0, 1'b0);
        send_word(MON_ID_RESET, 1'b0, 1'b0);
        // neither ID matches, ends on pattern A
        send_word(32'd20, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(32'h1234_5678, 1'b0, 1'b0);
        send_word(EOF_PAT_A, 1'b0, 1'b0);
        // bad lengths: zero, short, unaligned, all ones; clear on one
        send_word(32'd0, 1'b0, 1'b0);
        send_word(32'd12, 1'b0, 1'b1);
        send_word(32'd17, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        // only config ID matches, record ends with the buffer
        send_word(32'd24, 1'b0, 1'b0);
        send_word(32'h1, 1'b0, 1'b0);
        send_word(CFG_ID_RESET, 1'b0, 1'b0);
        send_word(32'hDEAD_BEEF, 1'b0, 1'b0);
        send_word(32'h5, 1'b0, 1'b0);
        send_word(EOF_PAT_D, 1'b1, 1'b0);
        // largest length, cut off by buffer end with a clear
        send_word(32'hFFFF_FFFC, 1'b0, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(32'h0, 1'b1, 1'b1);
        // buffer ends on a bad length word, then on a good one
        send_word(32'h7, 1'b1, 1'b0);
        send_word(32'h10, 1'b1, 1'b0);

        run_random(360);

        // all-zero IDs, no sender gaps
        drain();
        set_register(REG_CFG_ID, 32'h0);
        set_register(REG_MON_ID, 32'h0);
        gaps_on = 1'b0;
        run_random(360);

        // all-ones IDs
        drain();
        set_register(REG_CFG_ID, 32'hFFFF_FFFF);
        set_register(REG_MON_ID, 32'hFFFF_FFFF);
        gaps_on = 1'b1;
        run_random(360);

        // monitor ID equal to an EOF pattern: sixteen-byte record passes both
        drain();
        set_register(REG_CFG_ID, $urandom());
        set_register(REG_MON_ID, EOF_PAT_C);
        gaps_on = ($urandom_range(0, 1) != 0);
        send_word(32'd16, 1'b0, 1'b0);
        send_word($urandom(), 1'b0, 1'b0);
        send_word($urandom(), 1'b0, 1'b0);
        send_word(EOF_PAT_C, 1'b1, 1'b0);
        run_random(360);

        // back to reset values
        drain();
        set_register(REG_CFG_ID, CFG_ID_RESET);
        set_register(REG_MON_ID, MON_ID_RESET);
        gaps_on = 1'b1;
        run_random(360);

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
